[sv/cfr_pkg.sv]
// ----------------------------------------------------------------------------
// cfr_pkg: shared constants for the clipped rectangle fill block
// Framebuffer geometry limits and the configuration register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

  localparam int ROWS      = 64;
  localparam int MAX_WIDTH = 1024;

  localparam logic [1:0] REG_SPAN_ORIGIN = 2'd0;
  localparam logic [1:0] REG_SPAN_WIDTH  = 2'd1;
  localparam logic [1:0] REG_ROW_STRIDE  = 2'd2;

endpackage

`default_nettype wire

[sv/clipped_rect_fill_4bpp.sv]
// ----------------------------------------------------------------------------
// clipped_rect_fill_4bpp: clipped rectangle fill for a 4bpp framebuffer
// Clips rectangles against the window and the row range and issues one
// nibble-packed row write command per visible row.
// ----------------------------------------------------------------------------
// A rectangle request passes three pipeline stages (offset, clip, byte
// decode) and then reaches the output register, which issues one row command
// per cycle while the downstream side takes them, so a rectangle holds the
// output until all its visible rows have been issued. A new request can be
// taken every cycle while the stages ahead have room. Rectangles that clip to
// nothing are dropped at the clip stage.
`timescale 1ns / 1ps
`default_nettype none

module clipped_rect_fill_4bpp
  import cfr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               rect_valid,
  output logic                    rect_ready,
  input  wire logic signed [31:0] rect_x,
  input  wire logic signed [9:0]  rect_y,
  input  wire logic [10:0]        rect_w,
  input  wire logic [9:0]         rect_h,
  input  wire logic [3:0]         colour,
  output logic                    cmd_valid,
  input  wire logic               cmd_ready,
  output logic [5:0]              row,
  output logic [8:0]              start_byte,
  output logic                    lead_nibble,
  output logic [9:0]              full_bytes,
  output logic                    tail_nibble,
  output logic [7:0]              fill_byte,
  output logic                    last_row
);

  localparam logic [10:0] MAX_W   = 11'(MAX_WIDTH);
  localparam logic [6:0]  ROW_END = 7'(ROWS);

  // Configuration registers.
  logic signed [31:0] span_origin;
  logic [10:0]        span_width;
  logic [9:0]         row_stride;

  always_ff @(posedge clk) begin
    if (rst) begin
      span_origin <= '0;
      span_width  <= 11'd144;
      row_stride  <= 10'd72;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPAN_ORIGIN: span_origin <= cfg_data;
        REG_SPAN_WIDTH:  span_width  <= cfg_data[10:0];
        REG_ROW_STRIDE:  row_stride  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshakes.
  logic s1_valid, s2_valid, s3_valid;
  logic s1_ready, s2_ready, s3_ready, emit_take;

  assign emit_take  = !cmd_valid || (cmd_ready && last_row);
  assign s3_ready   = !s3_valid || emit_take;
  assign s2_ready   = !s2_valid || s3_ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign rect_ready = s1_ready;

  // Stage 1: window offsets, effective window width, row range.
  logic signed [32:0] s1_i0;
  logic signed [33:0] s1_i1;
  logic [10:0]        s1_win;
  logic [8:0]         s1_ylo;
  logic signed [11:0] s1_yhi;
  logic [3:0]         s1_colour;

  logic signed [32:0] i0_next;
  logic [10:0]        stride2;
  logic [10:0]        win_a;
  logic [10:0]        win_next;

  always_comb begin
    i0_next  = 33'(rect_x) - 33'(span_origin);
    stride2  = {row_stride, 1'b0};
    win_a    = (span_width > MAX_W) ? MAX_W : span_width;
    win_next = (win_a > stride2) ? stride2 : win_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= rect_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_i0     <= i0_next;
      s1_i1     <= 34'(i0_next) + 34'($signed({1'b0, rect_w}));
      s1_win    <= win_next;
      s1_ylo    <= rect_y[9] ? 9'd0 : rect_y[8:0];
      s1_yhi    <= 12'(rect_y) + 12'($signed({1'b0, rect_h}));
      s1_colour <= colour;
    end
  end

  // Stage 2: clip on x and y, drop empty results.
  logic [9:0]  s2_i0;
  logic [10:0] s2_i1;
  logic [5:0]  s2_y0;
  logic [6:0]  s2_y1;
  logic [3:0]  s2_colour;

  logic signed [32:0] i0c;
  logic               x_empty;
  logic               y_empty;
  logic [10:0]        i1c;
  logic [6:0]         y1c;

  always_comb begin
    i0c     = s1_i0[32] ? 33'sd0 : s1_i0;
    x_empty = (s1_i1 <= 34'(i0c)) || ($signed({22'd0, s1_win}) <= i0c);
    i1c     = (s1_i1 > $signed({23'd0, s1_win})) ? s1_win : s1_i1[10:0];
    y_empty = (s1_yhi <= $signed({3'd0, s1_ylo})) || ({1'b0, s1_ylo} >= 10'(ROW_END));
    y1c     = (s1_yhi > $signed({5'd0, ROW_END})) ? ROW_END : s1_yhi[6:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid && !x_empty && !y_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_i0     <= i0c[9:0];
      s2_i1     <= i1c;
      s2_y0     <= s1_ylo[5:0];
      s2_y1     <= y1c;
      s2_colour <= s1_colour;
    end
  end

  // Stage 3: split the span into lead nibble, whole bytes and tail nibble.
  logic [8:0] s3_start;
  logic       s3_lead;
  logic [9:0] s3_full;
  logic       s3_tail;
  logic [7:0] s3_fill;
  logic [5:0] s3_y0;
  logic [6:0] s3_y1;

  logic [10:0] pos;
  logic [10:0] whole;
  logic [10:0] pos_end;
  logic [10:0] run;

  always_comb begin
    pos     = {1'b0, s2_i0} + {10'd0, s2_i0[0]};
    whole   = {s2_i1[10:1], 1'b0};
    run     = whole - pos;
    pos_end = (whole > pos) ? whole : pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_start <= s2_i0[9:1];
      s3_lead  <= s2_i0[0];
      s3_full  <= (whole > pos) ? run[10:1] : 10'd0;
      s3_tail  <= pos_end < s2_i1;
      s3_fill  <= {s2_colour, s2_colour};
      s3_y0    <= s2_y0;
      s3_y1    <= s2_y1;
    end
  end

  // Stage 4: output register walks the visible rows.
  logic [6:0] y_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (emit_take) begin
      cmd_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_take) begin
      row         <= s3_y0;
      y_end       <= s3_y1;
      last_row    <= ({1'b0, s3_y0} + 7'd1) == s3_y1;
      start_byte  <= s3_start;
      lead_nibble <= s3_lead;
      full_bytes  <= s3_full;
      tail_nibble <= s3_tail;
      fill_byte   <= s3_fill;
    end else if (cmd_ready) begin
      row      <= row + 6'd1;
      last_row <= ({1'b0, row} + 7'd2) == y_end;
    end
  end

  // A row that is not the last one always has a successor inside the frame.
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !last_row |-> row != 6'(ROWS - 1))
    else $error("non-final row command on the bottom row");

  // The command never reaches past the maximum window width in its row.
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> ({2'b0, start_byte, 1'b0} + {11'd0, lead_nibble} +
                   {1'b0, full_bytes, 1'b0} + {11'd0, tail_nibble}) <= {1'b0, MAX_W})
    else $error("row command extends beyond the window");

  // After a taken non-final row, the next row follows directly.
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && !last_row |=> cmd_valid && row == $past(row) + 6'd1)
    else $error("row sequence broken");

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the clipped rectangle fill block
// Sends rectangles under a series of window settings, from the reset window
// to the extreme origins, an empty window and odd widths. Each accepted
// request is expanded into its expected row commands, and every command the
// block issues is compared against them in order. Both handshakes are
// throttled at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
  import cfr_pkg::*;
();

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [5:0] row;
    logic [8:0] start_byte;
    logic       lead_nibble;
    logic [9:0] full_bytes;
    logic       tail_nibble;
    logic [7:0] fill_byte;
    logic       last_row;
  } row_cmd_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [9:0]  y;
    logic [10:0]        w;
    logic [9:0]         h;
    logic [3:0]         c;
  } rect_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_MOSTLY} rx_mode_t;

  class fill_scoreboard;
    longint origin;
    longint span_w;
    longint stride;
    row_cmd_t expected_cmds[$];
    int mismatches;
    int cmds_checked;
    int rects;
    int empty_rects;

    function new();
      origin = 0;
      span_w = 144;
      stride = 72;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_SPAN_ORIGIN: origin = longint'($signed(data));
        REG_SPAN_WIDTH:  span_w = longint'(data[10:0]);
        REG_ROW_STRIDE:  stride = longint'(data[9:0]);
        default: ;
      endcase
    endfunction

    function longint window_width();
      longint win;
      win = span_w;
      if (win > MAX_WIDTH) win = MAX_WIDTH;
      if (win > 2 * stride) win = 2 * stride;
      return win;
    endfunction

    function int pending_count();
      return expected_cmds.size();
    endfunction

    function string fmt_cmd(row_cmd_t c);
      return $sformatf("row %0d start %0d lead %0d full %0d tail %0d fill %02h last %0d",
                       c.row, c.start_byte, c.lead_nibble, c.full_bytes,
                       c.tail_nibble, c.fill_byte, c.last_row);
    endfunction

    function void note_rect(logic signed [31:0] x, logic signed [9:0] y, logic [10:0] w,
                            logic [9:0] h, logic [3:0] c);
      longint win, left, right, top, bottom, pos, whole, full, r;
      row_cmd_t cmd;
      rects++;
      win = window_width();
      left = longint'(x) - origin;
      right = left + longint'(w);
      if (left < 0) left = 0;
      if (right > win) right = win;
      top = longint'(y);
      bottom = top + longint'(h);
      if (top < 0) top = 0;
      if (bottom > ROWS) bottom = ROWS;
      if (right <= left || bottom <= top) begin
        empty_rects++;
        return;
      end
      cmd.lead_nibble = left[0];
      pos = left + longint'(cmd.lead_nibble);
      whole = right - (right & 1);
      full = 0;
      if (whole > pos) begin
        full = (whole - pos) >>> 1;
        pos = whole;
      end
      cmd.tail_nibble = (pos < right);
      cmd.start_byte = 9'(left >>> 1);
      cmd.full_bytes = 10'(full);
      cmd.fill_byte = {c, c};
      for (r = top; r < bottom; r++) begin
        cmd.row = 6'(r);
        cmd.last_row = (r + 1 == bottom);
        expected_cmds.push_back(cmd);
      end
    endfunction

    function void check_cmd(row_cmd_t got);
      row_cmd_t exp_cmd;
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected command: %s", fmt_cmd(got));
        return;
      end
      exp_cmd = expected_cmds.pop_front();
      cmds_checked++;
      if (got.row !== exp_cmd.row || got.start_byte !== exp_cmd.start_byte ||
          got.lead_nibble !== exp_cmd.lead_nibble || got.full_bytes !== exp_cmd.full_bytes ||
          got.tail_nibble !== exp_cmd.tail_nibble || got.fill_byte !== exp_cmd.fill_byte ||
          got.last_row !== exp_cmd.last_row) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t: expected %s", $realtime, fmt_cmd(exp_cmd));
          $display("                 got      %s", fmt_cmd(got));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic rect_valid;
  logic rect_ready;
  logic signed [31:0] rect_x;
  logic signed [9:0] rect_y;
  logic [10:0] rect_w;
  logic [9:0] rect_h;
  logic [3:0] colour;
  logic cmd_valid;
  logic cmd_ready = 1'b0;
  logic [5:0] row;
  logic [8:0] start_byte;
  logic lead_nibble;
  logic [9:0] full_bytes;
  logic tail_nibble;
  logic [7:0] fill_byte;
  logic last_row;

  fill_scoreboard board = new();
  int burst_left = 0;
  int windows = 1;
  rx_mode_t rx_mode = RX_OPEN;
  int rx_mode_left = 0;
  int rx_beat = 0;

  clipped_rect_fill_4bpp dut (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && cmd_ready)
        board.check_cmd(row_cmd_t'{row, start_byte, lead_nibble, full_bytes,
                                   tail_nibble, fill_byte, last_row});
      if (rect_valid && rect_ready)
        board.note_rect(rect_x, rect_y, rect_w, rect_h, colour);
    end
  end

  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(40, 200);
    end
    rx_mode_left--;
    rx_beat++;
    case (rx_mode)
      RX_OPEN:         cmd_ready <= 1'b1;
      RX_COIN:         cmd_ready <= 1'($urandom_range(0, 1));
      RX_EVERY_FOURTH: cmd_ready <= (rx_beat % 4 == 0);
      default:         cmd_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  initial begin
    #6_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic issue_rect(input rect_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        rect_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    rect_valid <= 1'b1;
    rect_x <= r.x;
    rect_y <= r.y;
    rect_w <= r.w;
    rect_h <= r.h;
    colour <= r.c;
    @(posedge clk);
    while (!rect_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    rect_valid <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk);
    @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    board.set_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic program_window(input logic [31:0] origin, input logic [31:0] span,
                                input logic [31:0] stride);
    write_reg(REG_SPAN_ORIGIN, origin);
    write_reg(REG_SPAN_WIDTH, span);
    write_reg(REG_ROW_STRIDE, stride);
    write_reg(REG_UNUSED, $urandom);
    cfg_we <= 1'b0;
    windows++;
  endtask

  function automatic rect_t random_rect();
    rect_t r;
    int pick;
    longint win, off;
    logic [31:0] bits;
    win = board.window_width();
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      bits = $urandom;
      r.x = bits;
      bits = $urandom;
      r.y = bits[9:0];
      r.w = bits[20:10];
      bits = $urandom;
      r.h = bits[9:0];
    end else begin
      off = longint'($urandom_range(0, 32'(win) + 80)) - 40;
      r.x = 32'(board.origin + off);
      r.w = (pick < 25) ? 11'($urandom) : 11'($urandom_range(0, 32'(win) + 40));
      r.y = 10'(int'($urandom_range(0, 80)) - 12);
      r.h = (pick < 30) ? 10'($urandom) : 10'($urandom_range(0, 10));
    end
    r.c = 4'($urandom);
    return r;
  endfunction

  task automatic random_rects(input int count);
    repeat (count) issue_rect(random_rect());
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_SPAN_ORIGIN;
    cfg_data = '0;
    rect_valid = 1'b0;
    rect_x = '0;
    rect_y = '0;
    rect_w = '0;
    rect_h = '0;
    colour = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset window: 144 pixels starting at x = 0.
    issue_rect(rect_t'{32'sd0, 10'sd0, 11'd144, 10'd64, 4'hF});
    issue_rect(rect_t'{32'sd1, 10'sd3, 11'd2, 10'd2, 4'h5});
    issue_rect(rect_t'{32'sd1, 10'sd10, 11'd1, 10'd1, 4'hA});
    issue_rect(rect_t'{32'sd0, 10'sd20, 11'd1, 10'd1, 4'h0});
    issue_rect(rect_t'{32'sd4, 10'sd5, 11'd0, 10'd3, 4'h1});
    issue_rect(rect_t'{32'sd4, 10'sd5, 11'd9, 10'd0, 4'h2});
    issue_rect(rect_t'{32'sd7, 10'h200, 11'd20, 10'h3FF, 4'h3});
    issue_rect(rect_t'{32'sd7, 10'sd511, 11'd20, 10'd1, 4'h4});
    issue_rect(rect_t'{32'sd9, 10'sd63, 11'd30, 10'h3FF, 4'h6});
    issue_rect(rect_t'{32'sd9, -10'sd5, 11'd30, 10'd5, 4'h7});
    issue_rect(rect_t'{32'sd9, -10'sd5, 11'd30, 10'd6, 4'h8});
    issue_rect(rect_t'{32'h8000_0000, 10'sd0, 11'h7FF, 10'd2, 4'h9});
    issue_rect(rect_t'{32'h7FFF_FFFF, 10'sd0, 11'h7FF, 10'd2, 4'hB});
    issue_rect(rect_t'{32'hFFFF_FFFF, 10'sd1, 11'd4, 10'd2, 4'hC});
    issue_rect(rect_t'{-32'sd10, 10'sd30, 11'd20, 10'd3, 4'hD});
    issue_rect(rect_t'{32'sd140, 10'sd40, 11'h7FF, 10'd2, 4'hE});
    issue_rect(rect_t'{32'sd143, 10'sd50, 11'd10, 10'd2, 4'h5});
    issue_rect(rect_t'{32'sd144, 10'sd50, 11'd10, 10'd2, 4'hA});
    random_rects(50);
    wait_drained();

    // Widest window at the most negative origin.
    program_window(32'h8000_0000, 32'd1024, 32'd512);
    issue_rect(rect_t'{32'h8000_0000, 10'sd0, 11'h7FF, 10'd2, 4'h9});
    issue_rect(rect_t'{32'h8000_0000 + 32'd1023, 10'sd62, 11'd1, 10'd5, 4'h3});
    issue_rect(rect_t'{32'h8000_0001, 10'sd7, 11'h7FF, 10'd1, 4'h6});
    issue_rect(rect_t'{32'h8000_0000, 10'sd8, 11'd1023, 10'd1, 4'hC});
    issue_rect(rect_t'{32'h7FFF_FFFF, 10'sd0, 11'h7FF, 10'd4, 4'hF});
    random_rects(45);
    wait_drained();

    program_window(32'h7FFF_FFFF, 32'd0, 32'd1);
    random_rects(20);
    wait_drained();

    // Width above the maximum and stride at its field limit, upper bits junk.
    program_window($urandom, {21'($urandom_range(0, 32'h1F_FFFF)), 11'h7FF},
                   {22'($urandom_range(0, 32'h3F_FFFF)), 10'h3FF});
    random_rects(50);
    wait_drained();

    program_window(-32'sd3, 32'd300, 32'd100);
    random_rects(30);
    wait_drained();

    program_window($urandom, 32'd1024, 32'd0);
    random_rects(15);
    wait_drained();

    program_window(32'd7, 32'd33, 32'd512);
    random_rects(40);
    wait_drained();

    program_window($urandom, $urandom, $urandom);
    random_rects(40);
    wait_drained();

    $display("Covered %0d rectangles (%0d clipped to nothing) across %0d window settings.",
             board.rects, board.empty_rects, windows);
    $display("Checked %0d row commands: %0d mismatches, %0d still outstanding.",
             board.cmds_checked, board.mismatches, board.pending_count());
    if (board.mismatches == 0 && board.pending_count() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[clipped_rect_fill_4bpp.f]
sv/cfr_pkg.sv
sv/clipped_rect_fill_4bpp.sv
tb/tb.sv
